// ===== design/ptt_pkg.sv =====
// Shared constants and types for the PDO transmit trigger.
`default_nettype none
package ptt_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int CHANNELS_DEF = 4;

	localparam int CMD_W      = 3;
	localparam int CHAN_IDX_W = 2;
	localparam int NMT_W      = 8;
	localparam int TYPE_W     = 8;
	localparam int PERIOD_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FIRE_W     = 4;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	localparam int IN_IDX_LO  = 0;
	localparam int IN_NMT_LO  = IN_IDX_LO + CHAN_IDX_W;
	localparam int OUT_STOP_BIT   = FIRE_W;
	localparam int OUT_REMOTE_BIT = FIRE_W + 1;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SYNC   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOTE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NMT    = 3'd4;

	localparam logic [NMT_W-1:0] NMT_START      = 8'd1;
	localparam logic [NMT_W-1:0] NMT_STOP       = 8'd2;
	localparam logic [NMT_W-1:0] NMT_PREOP      = 8'd128;
	localparam logic [NMT_W-1:0] NMT_RESET_APP  = 8'd129;
	localparam logic [NMT_W-1:0] NMT_RESET_COMM = 8'd130;

	localparam logic [TYPE_W-1:0] TYPE_SYNC       = 8'd1;
	localparam logic [TYPE_W-1:0] TYPE_REMOTE_MIN = 8'd253;
	localparam logic [TYPE_W-1:0] TYPE_TIMER_MIN  = 8'd254;

	localparam logic [PERIOD_W-1:0] COUNT_MAX = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BASE = 3'd4;

	typedef struct packed {
		logic tick;
		logic sync;
		logic scan;
		logic start;
		logic remote;
		logic type_we;
		logic period_we;
	} ptt_chan_ctl_t;

endpackage
`default_nettype wire

// ===== design/pdo_transmit_trigger_top.sv =====
// PDO transmit trigger: decides which transmit channels fire on each event.
//
// Input beats arrive on the s_ group: s_tuser carries the event kind (tick,
// sync, remote request, scan, network command), s_tdata the channel index
// and the network command code. Every accepted beat yields exactly one
// result beat on the m_ group: the fire mask, the stop flag and the
// remote-frame flag.
// Registers are written over the cfg_ port (index 0..3 types, 4..7
// periods); cfg_ready is always high and a write also preloads the
// channel counter with its period. Write only while no beat is in flight.
// Results are registered ahead of m_tvalid. Throughput is one beat per
// cycle while s_tready is high: channel counters and compares update in the
// accept cycle. After reset all types are sync (1), periods and counters are
// zero, and the output is empty. On an output stall the output register and a
// skid stage hold up to two results; s_tready drops only when both are full.
`default_nettype none
module pdo_transmit_trigger_top #(
	parameter int CHANNELS = ptt_pkg::CHANNELS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire [ptt_pkg::IN_DATA_W-1:0]      s_tdata,  // chan_index[1:0], nmt_code[9:2], zero pad
	input  wire [ptt_pkg::CMD_W-1:0]          s_tuser,  // cmd[2:0]
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [ptt_pkg::OUT_DATA_W-1:0]    m_tdata,  // fire_mask[3:0], stop_readout[4],
	                                                    // remote_needed[5], zero pad
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [ptt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [ptt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ptt_pkg::*;

	logic [CMD_W-1:0]      cmd;
	logic [CHAN_IDX_W-1:0] chan_index;
	logic [NMT_W-1:0]      nmt_code;
	logic                  in_fire;
	logic                  cfg_fire;
	logic                  is_stop;
	logic [CHANNELS-1:0]   fire_vec;
	logic [CHANNELS-1:0]   remote_vec;
	logic [FIRE_W-1:0]     fire_mask;
	logic [OUT_DATA_W-1:0] result;

	assign cmd        = s_tuser;
	assign chan_index = s_tdata[IN_IDX_LO +: CHAN_IDX_W];
	assign nmt_code   = s_tdata[IN_NMT_LO +: NMT_W];
	assign in_fire    = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;
	assign cfg_fire   = cfg_valid && cfg_ready;

	assign is_stop = (cmd == CMD_NMT) &&
	                 ((nmt_code == NMT_STOP) || (nmt_code == NMT_PREOP) ||
	                  (nmt_code == NMT_RESET_APP) || (nmt_code == NMT_RESET_COMM));

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
		ptt_chan_ctl_t ctl;

		always_comb begin
			ctl.tick      = in_fire && (cmd == CMD_TICK);
			ctl.sync      = in_fire && (cmd == CMD_SYNC);
			ctl.scan      = in_fire && (cmd == CMD_SCAN);
			ctl.start     = in_fire && (cmd == CMD_NMT) && (nmt_code == NMT_START);
			ctl.remote    = in_fire && (cmd == CMD_REMOTE) &&
			                (chan_index == CHAN_IDX_W'(ch));
			ctl.type_we   = cfg_fire && (cfg_index == CFG_IDX_W'(ch));
			ctl.period_we = cfg_fire &&
			                (cfg_index == CFG_IDX_W'(REG_PERIOD_BASE + CFG_IDX_W'(ch)));
		end

		ptt_chan u_chan (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.cfg_data    (cfg_data),
			.fire        (fire_vec[ch]),
			.remote_type (remote_vec[ch])
		);
	end

	assign fire_mask = FIRE_W'(fire_vec);
	assign result    = OUT_DATA_W'({(|remote_vec), is_stop, fire_mask});

	ptt_skid #(
		.WIDTH (OUT_DATA_W)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

// ===== design/ptt_chan.sv =====
// One transmit channel: type and period registers, tick counter, fire decision.
`default_nettype none
module ptt_chan (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire ptt_pkg::ptt_chan_ctl_t      ctl,
	input  wire [ptt_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                             fire,
	output logic                             remote_type
);
	import ptt_pkg::*;

	logic [TYPE_W-1:0]   type_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] count_q;
	logic                timer_en;
	logic                due;

	assign timer_en    = (type_q >= TYPE_TIMER_MIN) && (period_q != '0);
	assign due         = timer_en && (count_q >= period_q);
	assign remote_type = type_q >= TYPE_REMOTE_MIN;
	assign fire        = (ctl.sync && (type_q == TYPE_SYNC)) ||
	                     (ctl.remote && remote_type) ||
	                     (ctl.scan && due);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q   <= TYPE_SYNC;
			period_q <= '0;
			count_q  <= '0;
		end else begin
			priority if (ctl.period_we) begin
				period_q <= cfg_data[PERIOD_W-1:0];
				count_q  <= cfg_data[PERIOD_W-1:0];
			end else if (ctl.type_we) begin
				type_q  <= cfg_data[TYPE_W-1:0];
				count_q <= period_q;
			end else if (ctl.tick) begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end else if (ctl.scan && due) begin
				count_q <= '0;
			end else if (ctl.start) begin
				count_q <= period_q;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/ptt_skid.sv =====
// Output register with a skid stage so the input side waits only when the skid stage is full.
`default_nettype none
module ptt_skid #(
	parameter int WIDTH = ptt_pkg::OUT_DATA_W
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire [WIDTH-1:0]  in_data,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [WIDTH-1:0] out_data
);
	logic             out_valid_q;
	logic [WIDTH-1:0] out_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             in_fire;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_ready || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_fire;
				end
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else begin
				out_data_q <= in_data;
			end
		end else if (in_fire) begin
			skid_data_q <= in_data;
		end
	end

endmodule
`default_nettype wire

// ===== design/ptt_checker.sv =====
// Port-level checks for the PDO transmit trigger, bound to the top level.
`default_nettype none
module ptt_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_tvalid,
	input wire                               s_tready,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [ptt_pkg::OUT_DATA_W-1:0]     m_tdata,
	input wire                               cfg_ready
);
	import ptt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_stop_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_STOP_BIT] |-> (m_tdata[FIRE_W-1:0] == '0))
		else $error("stop result also fires channels");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
		else $error("accepted beat did not reach the output");

	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
		else $error("input stalled without a stalled output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind pdo_transmit_trigger_top ptt_checker u_ptt_checker (.*);
`default_nettype wire
